// ===== hdl/i2csrf_pkg.sv =====
`timescale 1ns / 1ps

package i2csrf_pkg;

  localparam int unsigned DefRegCount = 256;

  typedef logic [7:0] byte_t;

  // Bus event / host access codes
  typedef enum logic [3:0] {
    OP_WR_ADDR = 4'd0,
    OP_WR_DATA = 4'd1,
    OP_STOP    = 4'd2,
    OP_NACK    = 4'd3,
    OP_RD_ADDR = 4'd4,
    OP_RD_ACK  = 4'd5,
    OP_RD_END  = 4'd6,
    OP_HOST_WR = 4'd7,
    OP_HOST_RD = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    NOTE_NONE     = 2'd0,
    NOTE_WR_DONE  = 2'd1,
    NOTE_RD_START = 2'd2,
    NOTE_RD_DONE  = 2'd3
  } notify_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // One store access request: at most one of read and write per cycle
  typedef struct packed {
    logic  rd_en;
    byte_t rd_addr;
    logic  wr_en;
    byte_t wr_addr;
    byte_t wr_data;
  } store_req_t;

endpackage

// ===== hdl/i2csrf_if.sv =====
`timescale 1ns / 1ps

interface i2csrf_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic [7:0] data;
  logic [7:0] host_index;

  modport source (output valid, output operation, output data, output host_index,
                  input ready);
  modport sink (input valid, input operation, input data, input host_index,
                output ready);
endinterface

interface i2csrf_out_if;
  logic       valid;
  logic       ready;
  logic       ack;
  logic [7:0] out_byte;
  logic [1:0] notify;
  logic [7:0] notify_start;
  logic [7:0] notify_length;

  modport source (output valid, output ack, output out_byte, output notify,
                  output notify_start, output notify_length, input ready);
  modport sink (input valid, input ack, input out_byte, input notify,
                input notify_start, input notify_length, output ready);
endinterface

// ===== hdl/i2csrf_ram.sv =====
`timescale 1ns / 1ps

module i2csrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/i2csrf_store.sv =====
`timescale 1ns / 1ps

module i2csrf_store
  import i2csrf_pkg::*;
#(
  parameter int unsigned RegCount = DefRegCount
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output byte_t      rd_data_o
);

  localparam int unsigned AddrW = $clog2(RegCount);

  logic [RegCount-1:0] valid_q;
  logic                rd_hit_q;
  logic                rd_in_range;
  logic                wr_in_range;
  logic                ram_we;
  byte_t               ram_rdata;

  // indexes at or beyond the store depth are dropped on write, read as zero
  assign rd_in_range = {1'b0, req_i.rd_addr} < 9'(RegCount);
  assign wr_in_range = {1'b0, req_i.wr_addr} < 9'(RegCount);
  assign ram_we      = req_i.wr_en && wr_in_range;

  // per-entry written flags stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[req_i.wr_addr[AddrW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_hit_q <= rd_in_range && valid_q[req_i.rd_addr[AddrW-1:0]];
      end
    end
  end

  i2csrf_ram #(
    .Width (8),
    .Depth (RegCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.wr_addr[AddrW-1:0]),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_data_o = rd_hit_q ? ram_rdata : 8'd0;

`ifndef SYNTHESIS
  a_no_rd_wr_same_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.rd_en && req_i.wr_en))
    else $error("store read and write in the same cycle");
`endif

endmodule

// ===== hdl/i2c_slave_register_file_unit.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Words carry
// -------  ---  ---------------------------------------------------------
// in_i     in   operation, data, host_index (one bus event or host access)
// out_o    out  ack, out_byte, notify, notify_start, notify_length
//
// Each input word is handled in ST_IDLE then ST_EXEC: the accept cycle issues the store read,
// and ST_EXEC does the modify/write-back and loads the output register.
// The store read is registered, so the fetched byte is only there in ST_EXEC.
// A new word is taken while the previous result waits in the output register;
// the unit only holds in ST_EXEC while that register is still full.
// Reset clears the store through per-entry written flags.
module i2c_slave_register_file_unit
  import i2csrf_pkg::*;
#(
  parameter int unsigned RegCount = DefRegCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2csrf_in_if.sink           in_i,
  i2csrf_out_if.source        out_o
);

  state_e     state_q, state_d;
  logic [3:0] op_q;
  byte_t      data_q, hidx_q;

  // transfer state
  byte_t      ptr_q, ptr_d;
  byte_t      len_q, len_d;
  logic       loaded_q, loaded_d;

  // output register
  logic       out_valid_q;
  logic       ack_q, ack_d;
  byte_t      obyte_q, obyte_d;
  notify_e    note_q, note_d;
  byte_t      nstart_q, nstart_d;
  byte_t      nlen_q, nlen_d;
  logic       finish;

  store_req_t req;
  byte_t      rd_data;

  i2csrf_store #(
    .RegCount (RegCount)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    req        = '0;
    ptr_d      = ptr_q;
    len_d      = len_q;
    loaded_d   = loaded_q;
    finish     = 1'b0;
    ack_d      = 1'b1;
    obyte_d    = 8'd0;
    note_d     = NOTE_NONE;
    nstart_d   = 8'd0;
    nlen_d     = 8'd0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d     = ST_EXEC;
          // fetch now so the byte is there for the execute cycle
          req.rd_en   = (in_i.operation == OP_RD_ADDR) || (in_i.operation == OP_RD_ACK) ||
                        (in_i.operation == OP_HOST_RD);
          req.rd_addr = (in_i.operation == OP_HOST_RD) ? in_i.host_index : ptr_q;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_o.ready) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
          unique case (op_q)
            OP_WR_ADDR: begin
              loaded_d = 1'b0;
            end
            OP_WR_DATA: begin
              if (loaded_q) begin
                req.wr_en   = 1'b1;
                req.wr_addr = ptr_q;
                req.wr_data = data_q;
                ptr_d       = ptr_q + 8'd1;
                len_d       = len_q + 8'd1;
              end else begin
                // first data byte after address is the register index
                ptr_d    = data_q;
                loaded_d = 1'b1;
                len_d    = 8'd0;
              end
            end
            OP_STOP: begin
              note_d   = NOTE_WR_DONE;
              nstart_d = ptr_q - len_q;
              nlen_d   = len_q;
            end
            OP_NACK: begin
              ack_d = 1'b0;
            end
            OP_RD_ADDR: begin
              note_d   = NOTE_RD_START;
              nstart_d = ptr_q;
              obyte_d  = rd_data;
              ptr_d    = ptr_q + 8'd1;
              len_d    = 8'd1;
            end
            OP_RD_ACK: begin
              obyte_d = rd_data;
              ptr_d   = ptr_q + 8'd1;
              len_d   = len_q + 8'd1;
            end
            OP_RD_END: begin
              note_d   = NOTE_RD_DONE;
              nstart_d = ptr_q - len_q;
              nlen_d   = len_q;
            end
            OP_HOST_WR: begin
              req.wr_en   = 1'b1;
              req.wr_addr = hidx_q;
              req.wr_data = data_q;
            end
            OP_HOST_RD: begin
              obyte_d = rd_data;
            end
            default: begin
              // unused codes: plain ack, nothing changes
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= 8'd0;
      len_q       <= 8'd0;
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      len_q    <= len_d;
      loaded_q <= loaded_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input word and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.operation;
      data_q <= in_i.data;
      hidx_q <= in_i.host_index;
    end
    if (finish) begin
      ack_q    <= ack_d;
      obyte_q  <= obyte_d;
      note_q   <= note_d;
      nstart_q <= nstart_d;
      nlen_q   <= nlen_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.ack           = ack_q;
  assign out_o.out_byte      = obyte_q;
  assign out_o.notify        = note_q;
  assign out_o.notify_start  = nstart_q;
  assign out_o.notify_length = nlen_q;

`ifndef SYNTHESIS
  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_EXEC))
    else $error("accepted word did not move to execute");

  a_host_keeps_ptr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && (op_q == OP_HOST_WR || op_q == OP_HOST_RD))
      |=> ($stable(ptr_q) && $stable(len_q) && $stable(loaded_q)))
    else $error("host access changed transfer state");

  a_quiet_note : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.notify == NOTE_NONE)
      |-> (out_o.notify_start == 8'd0 && out_o.notify_length == 8'd0))
    else $error("notify fields set without a notification");

  a_nack_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && !ack_d) |-> (op_q == OP_NACK))
    else $error("ack dropped on a word other than data nack");
`endif

endmodule
